/* sv/adpa_pkg.sv */
// Shared types and constants for the ARM data-processing ALU.
`default_nettype none

package adpa_pkg;

  typedef enum logic [3:0] {
    OPC_AND, OPC_EOR, OPC_SUB, OPC_RSB, OPC_ADD, OPC_ADC, OPC_SBC, OPC_RSC,
    OPC_TST, OPC_TEQ, OPC_CMP, OPC_CMN, OPC_ORR, OPC_MOV, OPC_BIC, OPC_MVN
  } opcode_t;

  typedef enum logic [1:0] {
    SH_LSL, SH_LSR, SH_ASR, SH_ROR
  } shift_kind_t;

  localparam logic [3:0]  REG_PC      = 4'd15;
  localparam logic [31:0] PC_PREFETCH = 32'd4;
  localparam logic [7:0]  SHIFT_WORD  = 8'd32;

  // Barrel shifter request, already decoded from the instruction.
  typedef struct packed {
    logic [31:0] val;
    shift_kind_t kind;
    logic [7:0]  amt;
    logic        pass;   // operand goes through unshifted, carry kept
    logic        rrx;    // rotate right extended by one
    logic        cin;
  } shift_req_t;

  typedef struct packed {
    logic [31:0] op1;
    logic [31:0] op2;
    logic        sc;     // shifter carry out
    opcode_t     opc;
    logic        s;
    logic [3:0]  rd;
    logic [3:0]  fin;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] result;
    logic [3:0]  rd;
    logic        wr;
    logic [3:0]  flags;
    logic        pc_wr;
    logic        restore;
  } alu_rsp_t;

endpackage

`default_nettype wire

/* sv/adpa_in_if.sv */
// Instruction channel: instruction word, operand values and incoming flags.
`default_nettype none

interface adpa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  logic [31:0] first_operand;
  logic [31:0] shift_source;
  logic [7:0]  shift_register_byte;
  logic [3:0]  flags_in;

  modport source (
    output valid, instruction, first_operand, shift_source, shift_register_byte, flags_in,
    input  ready
  );
  modport sink (
    input  valid, instruction, first_operand, shift_source, shift_register_byte, flags_in,
    output ready
  );
endinterface

`default_nettype wire

/* sv/adpa_out_if.sv */
// Result channel: ALU result, destination and flags.
`default_nettype none

interface adpa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic [3:0]  dest_index;
  logic        write_result;
  logic [3:0]  flags_out;
  logic        pc_written;
  logic        restore_status;

  modport source (
    output valid, result_value, dest_index, write_result, flags_out, pc_written,
    output restore_status,
    input  ready
  );
  modport sink (
    input  valid, result_value, dest_index, write_result, flags_out, pc_written,
    input  restore_status,
    output ready
  );
endinterface

`default_nettype wire

/* sv/adpa_shift.sv */
// Barrel shifter for operand 2 with shifter carry out.
`default_nettype none

module adpa_shift
  import adpa_pkg::*;
(
  input  shift_req_t  req,
  output logic [31:0] value,
  output logic        carry
);

  logic [63:0] lsl64;
  logic [63:0] lsr64;
  logic [63:0] asr64;
  logic [63:0] ror64;
  logic        big;
  logic        eq32;
  logic        sign;

  always_comb begin
    lsl64 = {32'b0, req.val} << req.amt[4:0];
    lsr64 = {req.val, 32'b0} >> req.amt[4:0];
    asr64 = 64'($signed({req.val, 32'b0}) >>> req.amt[4:0]);
    ror64 = {req.val, req.val} >> req.amt[4:0];
    big   = |req.amt[7:5];
    eq32  = (req.amt == SHIFT_WORD);
    sign  = req.val[31];

    if (req.pass) begin
      value = req.val;
      carry = req.cin;
    end else if (req.rrx) begin
      value = {req.cin, req.val[31:1]};
      carry = req.val[0];
    end else begin
      case (req.kind)
        SH_LSL: begin
          value = big ? 32'b0 : lsl64[31:0];
          carry = big ? (eq32 & req.val[0]) : lsl64[32];
        end
        SH_LSR: begin
          value = big ? 32'b0 : lsr64[63:32];
          carry = big ? (eq32 & sign) : lsr64[31];
        end
        SH_ASR: begin
          value = big ? {32{sign}} : asr64[63:32];
          carry = big ? sign : asr64[31];
        end
        SH_ROR: begin
          // amount multiple of 32 leaves the word as is, carry from bit 31
          value = ror64[31:0];
          carry = ror64[31];
        end
        default: begin
          value = req.val;
          carry = req.cin;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/adpa_alu.sv */
// Sixteen-opcode ALU with flag update and write/restore decode.
`default_nettype none

module adpa_alu
  import adpa_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [31:0] a;
  logic [31:0] b;
  logic        ci;
  logic        arith;
  logic [32:0] sum;
  logic [31:0] r;
  logic        c;
  logic        v;
  logic        test;
  logic        restore;
  logic        upd;

  always_comb begin
    a     = req.op1;
    b     = req.op2;
    ci    = 1'b0;
    arith = 1'b1;
    case (req.opc)
      OPC_SUB, OPC_CMP: begin a = req.op1; b = ~req.op2; ci = 1'b1; end
      OPC_RSB:          begin a = req.op2; b = ~req.op1; ci = 1'b1; end
      OPC_ADD, OPC_CMN: begin a = req.op1; b = req.op2;  ci = 1'b0; end
      OPC_ADC:          begin a = req.op1; b = req.op2;  ci = req.fin[1]; end
      OPC_SBC:          begin a = req.op1; b = ~req.op2; ci = req.fin[1]; end
      OPC_RSC:          begin a = req.op2; b = ~req.op1; ci = req.fin[1]; end
      default:          arith = 1'b0;
    endcase

    sum = {1'b0, a} + {1'b0, b} + {32'b0, ci};

    case (req.opc)
      OPC_AND, OPC_TST: r = req.op1 & req.op2;
      OPC_EOR, OPC_TEQ: r = req.op1 ^ req.op2;
      OPC_ORR:          r = req.op1 | req.op2;
      OPC_MOV:          r = req.op2;
      OPC_BIC:          r = req.op1 & ~req.op2;
      OPC_MVN:          r = ~req.op2;
      default:          r = sum[31:0];
    endcase

    c = arith ? sum[32] : req.sc;
    v = arith ? ((~(a[31] ^ b[31])) & (a[31] ^ sum[31])) : req.fin[0];

    test    = (req.opc == OPC_TST) || (req.opc == OPC_TEQ) ||
              (req.opc == OPC_CMP) || (req.opc == OPC_CMN);
    restore = (req.rd == REG_PC) && req.s;
    upd     = (req.s || test) && !restore;

    rsp.result  = test ? 32'b0 : r;
    rsp.rd      = req.rd;
    rsp.wr      = !test;
    rsp.flags   = upd ? {r[31], (r == 32'b0), c, v} : req.fin;
    rsp.pc_wr   = !test && (req.rd == REG_PC);
    rsp.restore = restore;
  end

endmodule

`default_nettype wire

/* sv/arm_data_processing_alu.sv */
// Top level: three-stage ARM data-processing execute pipeline.
//
//   channel | dir | payload                                               | takes on
//   cmd     | in  | instruction, first_operand, shift_source,              | valid & ready
//           |     | shift_register_byte, flags_in                         |
//   res     | out | result_value, dest_index, write_result, flags_out,     | valid & ready
//           |     | pc_written, restore_status                            |
//
// One item per clock while res is not stalled; stages are decode/prefetch adjust, barrel shifter,
// ALU and flags, each stage registered. A stall on res freezes the whole pipe;
// cmd.ready is high whenever the output register is empty or being taken.
// rst (synchronous) clears the stage valid bits only.
`default_nettype none

module arm_data_processing_alu
  import adpa_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  adpa_in_if.sink     cmd,
  adpa_out_if.source  res
);

  logic        en;

  // stage 1: decoded operands
  logic        v1;
  shift_req_t  sreq;
  shift_req_t  sreq_next;
  logic [31:0] op1_s1;
  logic [31:0] op1_next;
  opcode_t     opc_s1;
  logic        s_s1;
  logic [3:0]  rd_s1;
  logic [3:0]  fin_s1;

  // stage 2: ALU operands
  logic        v2;
  alu_req_t    areq;
  logic [31:0] op2;
  logic        sc;

  // stage 3: output register
  logic        v3;
  alu_rsp_t    rsp;
  alu_rsp_t    rsp_next;

  logic [31:0] ins;
  logic        by_reg;
  logic [4:0]  amt5;
  shift_kind_t kind;

  assign en        = !v3 || res.ready;
  assign cmd.ready = en;

  always_comb begin
    ins    = cmd.instruction;
    by_reg = ins[4];
    amt5   = ins[11:7];
    kind   = shift_kind_t'(ins[6:5]);

    sreq_next.cin  = cmd.flags_in[1];
    op1_next       = cmd.first_operand;
    if (ins[25]) begin
      sreq_next.val  = {24'b0, ins[7:0]};
      sreq_next.kind = SH_ROR;
      sreq_next.amt  = {3'b0, ins[11:8], 1'b0};
      sreq_next.pass = (ins[11:8] == 4'd0);
      sreq_next.rrx  = 1'b0;
    end else if (by_reg) begin
      // register shift: PC reads one word further ahead
      sreq_next.val  = cmd.shift_source + ((ins[3:0] == REG_PC) ? PC_PREFETCH : 32'b0);
      sreq_next.kind = kind;
      sreq_next.amt  = cmd.shift_register_byte;
      sreq_next.pass = (cmd.shift_register_byte == 8'd0);
      sreq_next.rrx  = 1'b0;
      if (ins[19:16] == REG_PC) begin
        op1_next = cmd.first_operand + PC_PREFETCH;
      end
    end else begin
      // immediate zero amount: LSR/ASR mean 32, ROR means RRX
      sreq_next.val  = cmd.shift_source;
      sreq_next.kind = kind;
      sreq_next.amt  = ((amt5 == 5'd0) && (kind == SH_LSR || kind == SH_ASR)) ?
                       SHIFT_WORD : {3'b0, amt5};
      sreq_next.pass = (amt5 == 5'd0) && (kind == SH_LSL);
      sreq_next.rrx  = (amt5 == 5'd0) && (kind == SH_ROR);
    end
  end

  adpa_shift u_shift (
    .req   (sreq),
    .value (op2),
    .carry (sc)
  );

  adpa_alu u_alu (
    .req (areq),
    .rsp (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= cmd.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sreq   <= sreq_next;
      op1_s1 <= op1_next;
      opc_s1 <= opcode_t'(cmd.instruction[24:21]);
      s_s1   <= cmd.instruction[20];
      rd_s1  <= cmd.instruction[15:12];
      fin_s1 <= cmd.flags_in;

      areq.op1 <= op1_s1;
      areq.op2 <= op2;
      areq.sc  <= sc;
      areq.opc <= opc_s1;
      areq.s   <= s_s1;
      areq.rd  <= rd_s1;
      areq.fin <= fin_s1;

      rsp <= rsp_next;
    end
  end

  assign res.valid          = v3;
  assign res.result_value   = rsp.result;
  assign res.dest_index     = rsp.rd;
  assign res.write_result   = rsp.wr;
  assign res.flags_out      = rsp.flags;
  assign res.pc_written     = rsp.pc_wr;
  assign res.restore_status = rsp.restore;

endmodule

`default_nettype wire

/* sv/adpa_checker.sv */
// Port-level assertions for the ARM data-processing ALU, bound to the top level.
`default_nettype none

module adpa_checker
  import adpa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cmd_valid,
  input wire logic        cmd_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [31:0] result_value,
  input wire logic [3:0]  dest_index,
  input wire logic        write_result,
  input wire logic        pc_written
);

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(result_value) && $stable(dest_index))
    else $error("stalled result item changed");

  // an empty output register never blocks the input side
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> cmd_ready)
    else $error("input stalled with empty output register");

  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !write_result |-> result_value == 32'b0)
    else $error("test/compare item carries nonzero result");

  a_pc: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pc_written == (write_result && dest_index == REG_PC))
    else $error("pc_written inconsistent with write and destination");

  // once the pipe has drained with no input, no item appears from nowhere
  a_drain: assert property (@(posedge clk) disable iff (rst)
    !cmd_valid && !res_valid ##1 !cmd_valid && !res_valid ##1 !cmd_valid && !res_valid
    |=> !res_valid)
    else $error("result item without an accepted input");

endmodule

bind arm_data_processing_alu adpa_checker u_adpa_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .result_value (res.result_value),
  .dest_index   (res.dest_index),
  .write_result (res.write_result),
  .pc_written   (res.pc_written)
);

`default_nettype wire

/* sim/arm_data_processing_alu_checker.sv */
// Checker for the data-processing ALU: predicts each instruction's result and compares.
module arm_data_processing_alu_checker
  import adpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  adpa_in_if          cmd,
  adpa_out_if         res,
  output int          errors,
  output int          outstanding,
  output int          results_seen,
  output logic [15:0] opcodes_seen,
  output int          restores_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  alu_rsp_t alu_results_q[$];

  initial begin
    errors        = 0;
    outstanding   = 0;
    results_seen  = 0;
    opcodes_seen  = '0;
    restores_seen = 0;
  end

  function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] w;
    w = {v, v} >> n;
    return w[31:0];
  endfunction

  // {overflow, carry, sum} of x + y + ci
  function automatic logic [33:0] add_cv(input logic [31:0] x, input logic [31:0] y,
                                         input logic ci);
    logic [32:0] s;
    logic [31:0] ov;
    s  = {1'b0, x} + {1'b0, y} + {32'd0, ci};
    ov = ~(x ^ y) & (x ^ s[31:0]);
    return {ov[31], s};
  endfunction

  function automatic alu_rsp_t dp_execute(input logic [31:0] ins, input logic [31:0] rn_val,
                                          input logic [31:0] rm_val, input logic [7:0] rs_byte,
                                          input logic [3:0] fin);
    alu_rsp_t    o;
    opcode_t     opc;
    shift_kind_t kind;
    logic [3:0]  rd, rn, rm;
    logic        s_bit, imm, by_reg, cin, vin, sc, c, v, logical, test, restore, upd;
    logic [4:0]  rot;
    logic [7:0]  amt;
    logic [31:0] a, m, op2, r;
    logic [33:0] sum;
    rd     = ins[15:12];
    rn     = ins[19:16];
    rm     = ins[3:0];
    s_bit  = ins[20];
    opc    = opcode_t'(ins[24:21]);
    imm    = ins[25];
    by_reg = ins[4];
    kind   = shift_kind_t'(ins[6:5]);
    cin    = fin[1];
    vin    = fin[0];
    a      = rn_val;
    m      = rm_val;
    sc     = cin;
    if (imm) begin
      rot = {ins[11:8], 1'b0};
      op2 = rotr32({24'd0, ins[7:0]}, rot);
      if (rot != 0) sc = op2[31];
    end else begin
      if (by_reg) begin
        amt = rs_byte;
        if (rn == REG_PC) a = a + PC_PREFETCH;
        if (rm == REG_PC) m = m + PC_PREFETCH;
      end else begin
        amt = {3'd0, ins[11:7]};
      end
      if (!by_reg && amt == 0) begin
        // immediate zero amount: LSR/ASR mean 32, ROR means RRX
        case (kind)
          SH_LSL: op2 = m;
          SH_LSR: begin sc = m[31]; op2 = '0; end
          SH_ASR: begin sc = m[31]; op2 = {32{m[31]}}; end
          default: begin sc = m[0]; op2 = {cin, m[31:1]}; end
        endcase
      end else if (amt == 0) begin
        op2 = m;
      end else begin
        case (kind)
          SH_LSL: begin
            if (amt < SHIFT_WORD) begin sc = m[32 - amt]; op2 = m << amt; end
            else begin sc = (amt == SHIFT_WORD) ? m[0] : 1'b0; op2 = '0; end
          end
          SH_LSR: begin
            if (amt < SHIFT_WORD) begin sc = m[amt - 1]; op2 = m >> amt; end
            else begin sc = (amt == SHIFT_WORD) ? m[31] : 1'b0; op2 = '0; end
          end
          SH_ASR: begin
            if (amt < SHIFT_WORD) begin sc = m[amt - 1]; op2 = $signed(m) >>> amt; end
            else begin sc = m[31]; op2 = {32{m[31]}}; end
          end
          default: begin
            if (amt[4:0] == 0) begin sc = m[31]; op2 = m; end
            else begin sc = m[amt[4:0] - 1]; op2 = rotr32(m, amt[4:0]); end
          end
        endcase
      end
    end

    logical = 1'b1;
    sum     = '0;
    case (opc)
      OPC_AND, OPC_TST: r = a & op2;
      OPC_EOR, OPC_TEQ: r = a ^ op2;
      OPC_SUB, OPC_CMP: begin sum = add_cv(a, ~op2, 1'b1); logical = 1'b0; end
      OPC_RSB:          begin sum = add_cv(op2, ~a, 1'b1); logical = 1'b0; end
      OPC_ADD, OPC_CMN: begin sum = add_cv(a, op2, 1'b0); logical = 1'b0; end
      OPC_ADC:          begin sum = add_cv(a, op2, cin); logical = 1'b0; end
      OPC_SBC:          begin sum = add_cv(a, ~op2, cin); logical = 1'b0; end
      OPC_RSC:          begin sum = add_cv(op2, ~a, cin); logical = 1'b0; end
      OPC_ORR:          r = a | op2;
      OPC_MOV:          r = op2;
      OPC_BIC:          r = a & ~op2;
      default:          r = ~op2;
    endcase
    if (logical) begin
      c = sc;
      v = vin;
    end else begin
      r = sum[31:0];
      c = sum[32];
      v = sum[33];
    end

    test    = (opc == OPC_TST) || (opc == OPC_TEQ) || (opc == OPC_CMP) || (opc == OPC_CMN);
    restore = (rd == REG_PC) && s_bit;
    upd     = (s_bit || test) && !restore;

    o.result  = test ? 32'd0 : r;
    o.rd      = rd;
    o.wr      = !test;
    o.flags   = upd ? {r[31], r == 32'd0, c, v} : fin;
    o.pc_wr   = !test && (rd == REG_PC);
    o.restore = restore;
    return o;
  endfunction

  always @(posedge clk) begin
    alu_rsp_t want, got;
    if (!rst) begin
      if (res.valid && res.ready) begin
        got.result  = res.result_value;
        got.rd      = res.dest_index;
        got.wr      = res.write_result;
        got.flags   = res.flags_out;
        got.pc_wr   = res.pc_written;
        got.restore = res.restore_status;
        results_seen = results_seen + 1;
        if (alu_results_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("tb: unexpected result %h rd %0d", got.result, got.rd);
        end else begin
          want = alu_results_q.pop_front();
          if (got !== want) begin
            errors = errors + 1;
            if (errors <= 10) begin
              $write("tb: mismatch (exp/act) result %h/%h rd %0d/%0d wr %b/%b ",
                     want.result, got.result, want.rd, got.rd, want.wr, got.wr);
              $display("flags %b/%b pc %b/%b restore %b/%b",
                       want.flags, got.flags, want.pc_wr, got.pc_wr,
                       want.restore, got.restore);
            end
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        want = dp_execute(cmd.instruction, cmd.first_operand, cmd.shift_source,
                          cmd.shift_register_byte, cmd.flags_in);
        alu_results_q.push_back(want);
        opcodes_seen[cmd.instruction[24:21]] = 1'b1;
        if (want.restore) restores_seen = restores_seen + 1;
      end
      outstanding = alu_results_q.size();
    end
  end
endmodule

/* sim/arm_data_processing_alu_tb.sv */
// Testbench top: clock, reset, instruction stimulus, result back-pressure and verdict.
module arm_data_processing_alu_tb;
  import adpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 400;
  localparam int STUCK_LIMIT  = 1000;

  logic clk;
  logic rst;

  adpa_in_if  cmd_ch ();
  adpa_out_if res_ch ();

  int          errors, outstanding, results_seen, restores_seen;
  logic [15:0] opcodes_seen;
  int          items_sent = 0;
  int          stuck = 0;
  int          send_quiet = 0;
  int          recv_quiet = 0;
  bit          long_hold_done = 1'b0;

  arm_data_processing_alu dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  arm_data_processing_alu_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd_ch),
    .res           (res_ch),
    .errors        (errors),
    .outstanding   (outstanding),
    .results_seen  (results_seen),
    .opcodes_seen  (opcodes_seen),
    .restores_seen (restores_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int idle_gap(inout int quiet);
    int pick;
    if (quiet > 0) begin
      quiet = quiet - 1;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet = $urandom_range(10, 30);
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] dp_word(input opcode_t opc, input logic s, input logic [3:0] rn,
                                          input logic [3:0] rd, input logic imm,
                                          input logic [11:0] op2);
    return {4'hE, 2'b00, imm, opc, s, rn, rd, op2};
  endfunction

  function automatic logic [11:0] sh_imm(input logic [3:0] rm, input shift_kind_t k,
                                         input logic [4:0] amt);
    return {amt, k, 1'b0, rm};
  endfunction

  function automatic logic [11:0] sh_reg(input logic [3:0] rm, input shift_kind_t k);
    return {4'd2, 1'b0, k, 1'b1, rm};
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] rand_amount();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd32;
      2: return 8'($urandom_range(33, 64));
      3: return 8'($urandom_range(1, 31));
      4: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_instruction();
    logic [31:0] ins;
    ins = $urandom;
    if ($urandom_range(0, 6) == 0) ins[15:12] = REG_PC;
    if ($urandom_range(0, 6) == 0) ins[19:16] = REG_PC;
    if ($urandom_range(0, 6) == 0) ins[3:0]   = REG_PC;
    if (!ins[25] && !ins[4] && $urandom_range(0, 3) == 0) ins[11:7] = '0;
    if (ins[25] && $urandom_range(0, 4) == 0) ins[11:8] = '0;
    return ins;
  endfunction

  task automatic send_item(input logic [31:0] ins, input logic [31:0] a, input logic [31:0] m,
                           input logic [7:0] rs, input logic [3:0] fl);
    int gap;
    gap = idle_gap(send_quiet);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid               <= 1'b1;
    cmd_ch.instruction         <= ins;
    cmd_ch.first_operand       <= a;
    cmd_ch.shift_source        <= m;
    cmd_ch.shift_register_byte <= rs;
    cmd_ch.flags_in            <= fl;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    items_sent = items_sent + 1;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // result side: random back-pressure plus one long hold while items keep coming
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    forever begin
      if (!long_hold_done && results_seen >= 120) begin
        long_hold_done = 1'b1;
        gap = 80;
      end else begin
        gap = idle_gap(recv_quiet);
      end
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("tb: stalled with %0d results outstanding", outstanding);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    clk                        = 1'b0;
    rst                        = 1'b1;
    cmd_ch.valid               = 1'b0;
    cmd_ch.instruction         = '0;
    cmd_ch.first_operand       = '0;
    cmd_ch.shift_source        = '0;
    cmd_ch.shift_register_byte = '0;
    cmd_ch.flags_in            = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // immediates: no rotation keeps C, rotation takes C from bit 31
    send_item(dp_word(OPC_AND, 1'b1, 4'd1, 4'd2, 1'b1, {4'd0, 8'hFF}), 32'hFFFF_FFFF,
              $urandom, 8'($urandom), 4'b0010);
    send_item(dp_word(OPC_EOR, 1'b1, 4'd1, 4'd2, 1'b1, {4'd1, 8'hFF}), 32'h0, $urandom,
              8'($urandom), 4'b0000);
    // immediate zero-amount shifts, RRX included
    send_item(dp_word(OPC_SUB, 1'b1, 4'd1, 4'd2, 1'b0, sh_imm(4'd3, SH_LSL, 5'd0)), 32'h0,
              32'h0, 8'($urandom), 4'b0000);
    send_item(dp_word(OPC_RSB, 1'b1, 4'd1, 4'd2, 1'b0, sh_imm(4'd3, SH_LSR, 5'd0)), 32'h1,
              32'h8000_0000, 8'($urandom), 4'b0000);
    send_item(dp_word(OPC_ADD, 1'b1, 4'd1, 4'd2, 1'b0, sh_imm(4'd3, SH_ASR, 5'd0)),
              32'h8000_0000, 32'h8000_0000, 8'($urandom), 4'b0000);
    send_item(dp_word(OPC_ADC, 1'b1, 4'd1, 4'd2, 1'b0, sh_imm(4'd3, SH_ROR, 5'd0)),
              32'h7FFF_FFFF, 32'h0, 8'($urandom), 4'b0010);
    // register shifts at 0, 4, 32 and beyond, then an immediate shift and a rotated immediate
    send_item(dp_word(OPC_SBC, 1'b1, 4'd1, 4'd2, 1'b0, sh_reg(4'd3, SH_LSL)), 32'h0, 32'h0,
              8'd0, 4'b0000);
    send_item(dp_word(OPC_RSC, 1'b1, 4'd1, 4'd2, 1'b0, sh_reg(4'd3, SH_LSL)), 32'h0, 32'h1,
              8'd32, 4'b0011);
    send_item(dp_word(OPC_TST, 1'b0, 4'd1, 4'd2, 1'b0, sh_reg(4'd3, SH_LSL)), 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 8'd33, 4'b1111);
    send_item(dp_word(OPC_TEQ, 1'b0, 4'd1, 4'd2, 1'b0, sh_reg(4'd3, SH_LSR)), 32'h8000_0000,
              32'h8000_0000, 8'd32, 4'b0000);
    send_item(dp_word(OPC_CMP, 1'b0, 4'd1, 4'd2, 1'b0, sh_reg(4'd3, SH_ASR)), 32'h7FFF_FFFF,
              32'h8000_0000, 8'd40, 4'b0000);
    send_item(dp_word(OPC_CMN, 1'b0, 4'd1, 4'd2, 1'b0, sh_reg(4'd3, SH_ROR)), 32'h7FFF_FFFF,
              32'h8000_0001, 8'd32, 4'b0000);
    send_item(dp_word(OPC_ORR, 1'b1, 4'd1, 4'd2, 1'b0, sh_reg(4'd3, SH_ROR)), 32'h0,
              32'h1234_5678, 8'd4, 4'b0000);
    send_item(dp_word(OPC_MOV, 1'b1, 4'd1, 4'd2, 1'b0, sh_reg(4'd3, SH_LSR)), 32'h0,
              32'hFFFF_FFFF, 8'd255, 4'b0110);
    send_item(dp_word(OPC_BIC, 1'b1, 4'd1, 4'd2, 1'b0, sh_imm(4'd3, SH_LSL, 5'd31)),
              32'hFFFF_FFFF, 32'h1, 8'($urandom), 4'b0000);
    send_item(dp_word(OPC_MVN, 1'b1, 4'd1, 4'd2, 1'b1, {4'd15, 8'h00}), $urandom, $urandom,
              8'($urandom), 4'b0000);
    // PC as Rn and Rm: prefetch only for register-specified shifts
    send_item(dp_word(OPC_ADD, 1'b0, REG_PC, 4'd3, 1'b0, sh_reg(REG_PC, SH_LSL)), 32'h100,
              32'h200, 8'd1, 4'b0000);
    send_item(dp_word(OPC_ADD, 1'b0, REG_PC, 4'd3, 1'b0, sh_imm(REG_PC, SH_LSL, 5'd1)),
              32'h100, 32'h200, 8'd1, 4'b0000);
    // Rd is PC: status restore with S, plain PC write without
    send_item(dp_word(OPC_MOV, 1'b1, 4'd1, REG_PC, 1'b1, {4'd0, 8'h00}), $urandom, $urandom,
              8'($urandom), 4'b1010);
    send_item(dp_word(OPC_MOV, 1'b0, 4'd1, REG_PC, 1'b1, {4'd0, 8'h40}), $urandom, $urandom,
              8'($urandom), 4'b0101);
    send_item(dp_word(OPC_CMP, 1'b1, 4'd1, REG_PC, 1'b1, {4'd0, 8'h00}), 32'h0, $urandom,
              8'($urandom), 4'b0101);
    // signed overflow on subtract, all-ones add without flag update
    send_item(dp_word(OPC_SUB, 1'b1, 4'd1, 4'd2, 1'b1, {4'd0, 8'h01}), 32'h8000_0000,
              $urandom, 8'($urandom), 4'b0000);
    send_item(dp_word(OPC_ADD, 1'b0, 4'd1, 4'd2, 1'b0, sh_imm(4'd3, SH_LSL, 5'd0)),
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'b1111);
    send_item(dp_word(OPC_RSB, 1'b1, 4'd1, 4'd2, 1'b0, sh_reg(4'd3, SH_ASR)), 32'hFFFF_FFFF,
              32'h7FFF_FFFF, 8'd31, 4'b0000);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        cmd_ch.valid <= 1'b0;
        wait_drained();
      end
      send_item(rand_instruction(), rand_word(), rand_word(), rand_amount(), 4'($urandom));
    end
    cmd_ch.valid <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    $display("tb: %0d instructions in, %0d results out, %0d of 16 opcodes",
             items_sent, results_seen, $countones(opcodes_seen));
    $display("tb: %0d status restores, %0d mismatches", restores_seen, errors);
    if (errors == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

/* filelist.f */
sv/adpa_pkg.sv
sv/adpa_in_if.sv
sv/adpa_out_if.sv
sv/adpa_shift.sv
sv/adpa_alu.sv
sv/arm_data_processing_alu.sv
sv/adpa_checker.sv
sim/arm_data_processing_alu_checker.sv
sim/arm_data_processing_alu_tb.sv
